/* src/sklos_pkg.sv */
`default_nettype none
package sklos_pkg;

  // Fixed-point formats.
  localparam int CF = 16;
  localparam int SF = 24;
  localparam int KF = 24;
  localparam int VW = 36;
  localparam int AW = VW - 1;
  localparam int BW = 29;
  localparam int PW = AW + BW;
  localparam int XW = 40;
  localparam int RW = 24;
  localparam int KVW = 19;
  localparam int TSH = 17 + CF - SF;
  localparam int MCW = $clog2(BW + 1);
  localparam int SCW = $clog2(RW + 1);
  localparam int NSRC = 29;

  typedef logic signed [VW-1:0] val_t;

  localparam val_t VAL_ONE = val_t'(64'sd1 <<< KF);

  // Kernel constants, rounded to Q.24.
  localparam val_t C_UNI =
    val_t'((64'sd2387324146 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_ANA =
    val_t'((64'sd33422538049 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_G8 =
    val_t'((64'sd25464790895 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_G16 =
    val_t'((64'sd50929581789 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_CA =
    val_t'((64'sd25464790895 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_CB =
    val_t'((64'sd152788745368 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_CC =
    val_t'((64'sd50929581789 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q1 =
    val_t'((64'sd64457752000 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q2 =
    val_t'((64'sd14323945000 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q3 =
    val_t'((64'sd1750704400 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q4 =
    val_t'((64'sd32228876000 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q5 =
    val_t'((64'sd107429587000 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q6 =
    val_t'((64'sd50133807100 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q7 =
    val_t'((64'sd5968310366 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q8 =
    val_t'((64'sd1352817016 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam val_t C_Q9 =
    val_t'((64'sd6445775200 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam logic [RW-1:0] R_THIRD =
    RW'((64'sd3333333330 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam logic [RW-1:0] R_TWOTHIRD =
    RW'((64'sd6666666670 * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
  localparam logic [RW-1:0] R_HALF = RW'(64'sd1 <<< (KF - 1));

  // Kernel select codes.
  localparam logic [2:0] KSEL_UNI = 3'd0;
  localparam logic [2:0] KSEL_ANA = 3'd1;
  localparam logic [2:0] KSEL_G2 = 3'd2;
  localparam logic [2:0] KSEL_CUB = 3'd3;
  localparam logic [2:0] KSEL_QUI = 3'd4;

  // Operand sources of the shared multiplier.
  typedef enum logic [4:0] {
    SRC_ZA, SRC_Q, SRC_R, SRC_OM, SRC_R2, SRC_R3, SRC_R4, SRC_OM2, SRC_OM3, SRC_T,
    SRC_K4R, SRC_PG8, SRC_RMK, SRC_KMR, SRC_RM3K, SRC_VSUM, SRC_DZ,
    SRC_CANA, SRC_CG8, SRC_CG16, SRC_CCB, SRC_CCC, SRC_CQ1, SRC_CQ2, SRC_CQ4,
    SRC_CQ5, SRC_CQ6, SRC_CQ7, SRC_CQ9
  } src_e;

  // Destinations of a product.
  typedef enum logic [3:0] {
    DST_X_SET, DST_X_ADD, DST_R2, DST_R3, DST_R4, DST_OM2, DST_OM3, DST_T,
    DST_S_SET, DST_S_ADD, DST_S_SUB, DST_TRAP
  } dst_e;

  // Multiply sequences.
  typedef enum logic [3:0] {
    PG_SQ, PG_COM, PG_ANA, PG_G8, PG_G16, PG_CIN, PG_COUT, PG_Q1, PG_Q2, PG_Q3,
    PG_UNI, PG_NONE, PG_TRAP
  } prog_e;

  typedef struct packed {
    src_e a;
    src_e b;
    dst_e d;
    logic last;
  } uop_t;

  function automatic uop_t mk(src_e a, src_e b, dst_e d, logic last);
    uop_t u;
    u.a = a;
    u.b = b;
    u.d = d;
    u.last = last;
    return u;
  endfunction

  // One multiply step of a sequence.
  function automatic uop_t uop(prog_e p, logic [2:0] i);
    uop_t u;
    u = mk(SRC_R, SRC_R, DST_T, 1'b1);
    unique case (p)
      PG_SQ: begin
        if (i == 3'd0) u = mk(SRC_ZA, SRC_ZA, DST_X_SET, 1'b0);
        else u = mk(SRC_Q, SRC_Q, DST_X_ADD, 1'b1);
      end
      PG_COM: begin
        case (i)
          3'd0: u = mk(SRC_R, SRC_R, DST_R2, 1'b0);
          3'd1: u = mk(SRC_R2, SRC_R, DST_R3, 1'b0);
          3'd2: u = mk(SRC_R2, SRC_R2, DST_R4, 1'b0);
          3'd3: u = mk(SRC_OM, SRC_OM, DST_OM2, 1'b0);
          default: u = mk(SRC_OM2, SRC_OM, DST_OM3, 1'b1);
        endcase
      end
      PG_ANA: begin
        case (i)
          3'd0: u = mk(SRC_OM2, SRC_OM2, DST_T, 1'b0);
          3'd1: u = mk(SRC_T, SRC_K4R, DST_T, 1'b0);
          default: u = mk(SRC_CANA, SRC_T, DST_S_SET, 1'b1);
        endcase
      end
      PG_G8: u = mk(SRC_CG8, SRC_PG8, DST_S_SET, 1'b1);
      PG_G16: u = mk(SRC_CG16, SRC_OM3, DST_S_SET, 1'b1);
      PG_CIN: begin
        if (i == 3'd0) u = mk(SRC_RMK, SRC_R2, DST_T, 1'b0);
        else u = mk(SRC_CCB, SRC_T, DST_S_SET, 1'b1);
      end
      PG_COUT: u = mk(SRC_CCC, SRC_OM3, DST_S_SET, 1'b1);
      PG_Q1: begin
        case (i)
          3'd0: u = mk(SRC_R4, SRC_KMR, DST_T, 1'b0);
          3'd1: u = mk(SRC_CQ1, SRC_T, DST_S_SET, 1'b0);
          default: u = mk(SRC_CQ2, SRC_R2, DST_S_SUB, 1'b1);
        endcase
      end
      PG_Q2: begin
        case (i)
          3'd0: u = mk(SRC_R4, SRC_RM3K, DST_T, 1'b0);
          3'd1: u = mk(SRC_CQ4, SRC_T, DST_S_SET, 1'b0);
          3'd2: u = mk(SRC_CQ5, SRC_R3, DST_S_ADD, 1'b0);
          3'd3: u = mk(SRC_CQ6, SRC_R2, DST_S_SUB, 1'b0);
          default: u = mk(SRC_CQ7, SRC_R, DST_S_ADD, 1'b1);
        endcase
      end
      PG_Q3: begin
        case (i)
          3'd0: u = mk(SRC_OM2, SRC_OM2, DST_T, 1'b0);
          3'd1: u = mk(SRC_T, SRC_OM, DST_T, 1'b0);
          default: u = mk(SRC_CQ9, SRC_T, DST_S_SET, 1'b1);
        endcase
      end
      PG_TRAP: u = mk(SRC_VSUM, SRC_DZ, DST_TRAP, 1'b1);
      default: u = mk(SRC_R, SRC_R, DST_T, 1'b1);
    endcase
    return u;
  endfunction

  // Constant added after the last product.
  function automatic val_t fin_add(prog_e p);
    val_t c;
    c = '0;
    case (p)
      PG_UNI: c = C_UNI;
      PG_CIN: c = C_CA;
      PG_Q1: c = C_Q3;
      PG_Q2: c = C_Q8;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Quintic pieces carry a factor of 27.
  function automatic logic fin_x27(prog_e p);
    return (p == PG_Q1) || (p == PG_Q2) || (p == PG_Q3);
  endfunction

endpackage
`default_nettype wire

/* src/sklos_mul.sv */
`default_nettype none
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module sklos_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [sklos_pkg::AW-1:0]     a_mag_i,
  input  logic [sklos_pkg::BW-1:0]     b_mag_i,
  output logic                         done_o,
  output logic [sklos_pkg::PW-1:0]     prod_o
);

  logic [sklos_pkg::AW-1:0]  a_q, a_d;
  logic [sklos_pkg::AW-1:0]  hi_q, hi_d;
  logic [sklos_pkg::BW-1:0]  lo_q, lo_d;
  logic [sklos_pkg::MCW-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [sklos_pkg::AW:0]    psum;

  // Add the multiplicand when the current multiplier bit is set.
  assign psum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? a_q : '0)};

  always_comb begin
    a_d = a_q;
    hi_d = hi_q;
    lo_d = lo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      a_d = a_mag_i;
      hi_d = '0;
      lo_d = b_mag_i;
      cnt_d = sklos_pkg::MCW'(sklos_pkg::BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d = psum[sklos_pkg::AW:1];
      lo_d = {psum[0], lo_q[sklos_pkg::BW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == sklos_pkg::MCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule
`default_nettype wire

/* src/sklos_sqrt.sv */
`default_nettype none
// Digit-by-digit square root: one root bit per cycle of floor(sqrt(rad << 16)).
module sklos_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [2*sklos_pkg::CF-1:0] rad_i,
  output logic                      done_o,
  output logic [sklos_pkg::RW-1:0]  root_o
);

  localparam int XSW = 2 * sklos_pkg::CF;
  localparam int RMW = sklos_pkg::RW + 2;

  logic [XSW-1:0]              xs_q, xs_d;
  logic [RMW-1:0]              rem_q, rem_d;
  logic [sklos_pkg::RW-1:0]    root_q, root_d;
  logic [sklos_pkg::SCW-1:0]   cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [RMW+1:0]              cur;
  logic [RMW+1:0]              trial;

  // Bring down the next two radicand bits and try the next root bit.
  assign cur = {rem_q, xs_q[XSW-1:XSW-2]};
  assign trial = (RMW + 2)'({root_q, 2'b01});

  always_comb begin
    xs_d = xs_q;
    rem_d = rem_q;
    root_d = root_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      xs_d = rad_i;
      rem_d = '0;
      root_d = '0;
      cnt_d = sklos_pkg::SCW'(sklos_pkg::RW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      xs_d = {xs_q[XSW-3:0], 2'b00};
      if (cur >= trial) begin
        rem_d = RMW'(cur - trial);
        root_d = {root_q[sklos_pkg::RW-2:0], 1'b1};
      end else begin
        rem_d = RMW'(cur);
        root_d = {root_q[sklos_pkg::RW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == sklos_pkg::SCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q <= xs_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

/* src/sph_kernel_cumulative_los_integrator_unit.sv */
// Outside the kernel support a request takes only the squared-radius products; inside it the
// square root and the products of the kernel shape and its piece follow. A row start skips the
// trapezoid product. The shared bit-serial multiplier runs up to 13 products per request; one
// request is in work at a time, and the next is taken in the cycle after its result is loaded.
// A finished result waits in an output register until taken.
// Reset (asynchronous, active low) clears kernel_select, previous value and z, sum, handshake.
`default_nettype none
module sph_kernel_cumulative_los_integrator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [16:0]        impact_q_i,
  input  logic signed [17:0] los_z_i,
  input  logic               row_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] cumulative_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SQRT = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_OUT  = 6'b100000
  } st_e;

  localparam int VW = sklos_pkg::VW;
  localparam int XW = sklos_pkg::XW;
  localparam int RW = sklos_pkg::RW;
  localparam int KVW = sklos_pkg::KVW;

  st_e                    state_q, state_d;
  logic [2:0]             ksel_q, ksel_d;
  logic [KVW-1:0]         pv_q, pv_d;
  logic signed [17:0]     pz_q, pz_d;
  logic signed [31:0]     sum_q, sum_d;
  logic                   outv_q, outv_d;
  sklos_pkg::prog_e       prog_q, prog_d;
  logic [2:0]             idx_q, idx_d;
  logic                   mgo_q, mgo_d;
  logic                   sgo_q, sgo_d;

  logic [16:0]            q_q, q_d;
  logic [17:0]            za_q, za_d;
  logic signed [17:0]     z_q, z_d;
  logic                   st_q, st_d;
  logic signed [18:0]     dz_q, dz_d;
  logic [XW-1:0]          x_q, x_d;
  logic [RW-1:0]          r_q, r_d;
  sklos_pkg::val_t        om_q, om_d, r2_q, r2_d, r3_q, r3_d, r4_q, r4_d;
  sklos_pkg::val_t        om2_q, om2_d, om3_q, om3_d, t_q, t_d, s_q, s_d;
  logic [KVW-1:0]         v_q, v_d;
  logic                   mneg_q, mneg_d;
  logic signed [31:0]     out_q, out_d;

  sklos_pkg::uop_t        cur;
  sklos_pkg::val_t        srcv [sklos_pkg::NSRC];
  sklos_pkg::val_t        opa, opb, rv;
  logic [sklos_pkg::AW-1:0] amag;
  logic [sklos_pkg::BW-1:0] bmag;
  logic                   mul_done;
  logic [sklos_pkg::PW-1:0] mprod;
  logic [sklos_pkg::PW:0] rsum;
  logic [VW-1:0]          rtrunc;
  sklos_pkg::val_t        rval;
  logic                   sq_done;
  logic [RW-1:0]          sq_root;
  sklos_pkg::prog_e       pick;
  sklos_pkg::val_t        fbase, fsum, f27, fk;
  logic [VW-1:0]          fr;
  logic [VW-sklos_pkg::KF+15:0] fu;
  logic [KVW-1:0]         vfin;
  logic [XW-1:0]          tsum;
  logic [XW-sklos_pkg::TSH-1:0] tmag;
  logic signed [33:0]     tinc, tacc;

  // Current multiply step and its operands.
  assign cur = sklos_pkg::uop(prog_q, idx_q);
  assign rv = $signed(VW'(r_q));

  always_comb begin
    srcv[sklos_pkg::SRC_ZA] = $signed(VW'(za_q));
    srcv[sklos_pkg::SRC_Q] = $signed(VW'(q_q));
    srcv[sklos_pkg::SRC_R] = rv;
    srcv[sklos_pkg::SRC_OM] = om_q;
    srcv[sklos_pkg::SRC_R2] = r2_q;
    srcv[sklos_pkg::SRC_R3] = r3_q;
    srcv[sklos_pkg::SRC_R4] = r4_q;
    srcv[sklos_pkg::SRC_OM2] = om2_q;
    srcv[sklos_pkg::SRC_OM3] = om3_q;
    srcv[sklos_pkg::SRC_T] = t_q;
    srcv[sklos_pkg::SRC_K4R] = sklos_pkg::VAL_ONE + (rv <<< 2);
    srcv[sklos_pkg::SRC_PG8] = sklos_pkg::VAL_ONE - ((r2_q <<< 2) + (r2_q <<< 1))
                               + ((r3_q <<< 2) + (r3_q <<< 1));
    srcv[sklos_pkg::SRC_RMK] = rv - sklos_pkg::VAL_ONE;
    srcv[sklos_pkg::SRC_KMR] = om_q;
    srcv[sklos_pkg::SRC_RM3K] = rv - ((sklos_pkg::VAL_ONE <<< 1) + sklos_pkg::VAL_ONE);
    srcv[sklos_pkg::SRC_VSUM] = $signed(VW'({1'b0, pv_q} + {1'b0, v_q}));
    srcv[sklos_pkg::SRC_DZ] = VW'(dz_q);
    srcv[sklos_pkg::SRC_CANA] = sklos_pkg::C_ANA;
    srcv[sklos_pkg::SRC_CG8] = sklos_pkg::C_G8;
    srcv[sklos_pkg::SRC_CG16] = sklos_pkg::C_G16;
    srcv[sklos_pkg::SRC_CCB] = sklos_pkg::C_CB;
    srcv[sklos_pkg::SRC_CCC] = sklos_pkg::C_CC;
    srcv[sklos_pkg::SRC_CQ1] = sklos_pkg::C_Q1;
    srcv[sklos_pkg::SRC_CQ2] = sklos_pkg::C_Q2;
    srcv[sklos_pkg::SRC_CQ4] = sklos_pkg::C_Q4;
    srcv[sklos_pkg::SRC_CQ5] = sklos_pkg::C_Q5;
    srcv[sklos_pkg::SRC_CQ6] = sklos_pkg::C_Q6;
    srcv[sklos_pkg::SRC_CQ7] = sklos_pkg::C_Q7;
    srcv[sklos_pkg::SRC_CQ9] = sklos_pkg::C_Q9;
  end

  assign opa = srcv[cur.a];
  assign opb = srcv[cur.b];
  assign amag = sklos_pkg::AW'(opa[VW-1] ? -opa : opa);
  assign bmag = sklos_pkg::BW'(opb[VW-1] ? -opb : opb);

  sklos_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (mgo_q),
    .a_mag_i (amag),
    .b_mag_i (bmag),
    .done_o  (mul_done),
    .prod_o  (mprod)
  );

  sklos_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sgo_q),
    .rad_i  (x_q[2*sklos_pkg::CF-1:0]),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // Product rounded to Q.24, half away from zero.
  assign rsum = {1'b0, mprod} + ((sklos_pkg::PW + 1)'(1) << (sklos_pkg::KF - 1));
  assign rtrunc = rsum[sklos_pkg::KF+VW-1:sklos_pkg::KF];
  assign rval = mneg_q ? -$signed(rtrunc) : $signed(rtrunc);

  // Kernel piece chosen from the select register and r.
  always_comb begin
    case (ksel_q)
      sklos_pkg::KSEL_UNI: pick = sklos_pkg::PG_UNI;
      sklos_pkg::KSEL_ANA: pick = sklos_pkg::PG_ANA;
      sklos_pkg::KSEL_G2:
        pick = (r_q < sklos_pkg::R_HALF) ? sklos_pkg::PG_G8 : sklos_pkg::PG_G16;
      sklos_pkg::KSEL_CUB:
        pick = (r_q < sklos_pkg::R_HALF) ? sklos_pkg::PG_CIN : sklos_pkg::PG_COUT;
      sklos_pkg::KSEL_QUI: begin
        if (r_q < sklos_pkg::R_THIRD) pick = sklos_pkg::PG_Q1;
        else if (r_q < sklos_pkg::R_TWOTHIRD) pick = sklos_pkg::PG_Q2;
        else pick = sklos_pkg::PG_Q3;
      end
      default: pick = sklos_pkg::PG_NONE;
    endcase
  end

  // Final kernel value: constant term, factor 27, rounding to Q3.16 and clamping.
  always_comb begin
    fbase = ((prog_q == sklos_pkg::PG_UNI) || (prog_q == sklos_pkg::PG_NONE)) ? '0 : s_q;
    fsum = fbase + sklos_pkg::fin_add(prog_q);
    f27 = (fsum <<< 4) + (fsum <<< 3) + (fsum <<< 1) + fsum;
    fk = sklos_pkg::fin_x27(prog_q) ? f27 : fsum;
    fr = fk + (VW'(1) << (sklos_pkg::KF - 17));
    fu = fr[VW-1:sklos_pkg::KF-16];
    if (fk[VW-1]) vfin = '0;
    else if (fu > (VW - sklos_pkg::KF + 16)'({KVW{1'b1}})) vfin = {KVW{1'b1}};
    else vfin = KVW'(fu);
  end

  // Trapezoid increment and saturating sum.
  assign tsum = x_q + (XW'(1) << (sklos_pkg::TSH - 1));
  assign tmag = tsum[XW-1:sklos_pkg::TSH];
  assign tinc = dz_q[18] ? -$signed(34'(tmag)) : $signed(34'(tmag));
  assign tacc = 34'(sum_q) + tinc;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    ksel_d = cfg_we_i ? cfg_data_i : ksel_q;
    pv_d = pv_q;
    pz_d = pz_q;
    sum_d = sum_q;
    outv_d = outv_q & ~out_ready_i;
    prog_d = prog_q;
    idx_d = idx_q;
    mgo_d = 1'b0;
    sgo_d = 1'b0;
    q_d = q_q;
    za_d = za_q;
    z_d = z_q;
    st_d = st_q;
    dz_d = dz_q;
    x_d = x_q;
    r_d = r_q;
    om_d = om_q;
    r2_d = r2_q;
    r3_d = r3_q;
    r4_d = r4_q;
    om2_d = om2_q;
    om3_d = om3_q;
    t_d = t_q;
    s_d = s_q;
    v_d = v_q;
    mneg_d = mgo_q ? (opa[VW-1] ^ opb[VW-1]) : mneg_q;
    out_d = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          q_d = impact_q_i;
          za_d = los_z_i[17] ? 18'(-los_z_i) : 18'(los_z_i);
          z_d = los_z_i;
          st_d = row_start_i;
          dz_d = 19'(los_z_i) - 19'(pz_q);
          prog_d = sklos_pkg::PG_SQ;
          idx_d = '0;
          mgo_d = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          // Store the product.
          case (cur.d)
            sklos_pkg::DST_X_SET: x_d = XW'(mprod);
            sklos_pkg::DST_X_ADD: x_d = x_q + XW'(mprod);
            sklos_pkg::DST_TRAP: x_d = XW'(mprod);
            sklos_pkg::DST_R2: r2_d = rval;
            sklos_pkg::DST_R3: r3_d = rval;
            sklos_pkg::DST_R4: r4_d = rval;
            sklos_pkg::DST_OM2: om2_d = rval;
            sklos_pkg::DST_OM3: om3_d = rval;
            sklos_pkg::DST_T: t_d = rval;
            sklos_pkg::DST_S_SET: s_d = rval;
            sklos_pkg::DST_S_ADD: s_d = s_q + rval;
            sklos_pkg::DST_S_SUB: s_d = s_q - rval;
            default: t_d = t_q;
          endcase
          if (!cur.last) begin
            idx_d = idx_q + 3'd1;
            mgo_d = 1'b1;
          end else begin
            case (prog_q)
              sklos_pkg::PG_SQ: begin
                if (x_d[XW-1:2*sklos_pkg::CF] == '0) begin
                  sgo_d = 1'b1;
                  state_d = ST_SQRT;
                end else begin
                  prog_d = sklos_pkg::PG_NONE;
                  state_d = ST_FIN;
                end
              end
              sklos_pkg::PG_COM: begin
                prog_d = pick;
                if ((pick == sklos_pkg::PG_UNI) || (pick == sklos_pkg::PG_NONE)) begin
                  state_d = ST_FIN;
                end else begin
                  idx_d = '0;
                  mgo_d = 1'b1;
                end
              end
              sklos_pkg::PG_TRAP: state_d = ST_ACC;
              default: state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          r_d = sq_root;
          om_d = sklos_pkg::VAL_ONE - $signed(VW'(sq_root));
          prog_d = sklos_pkg::PG_COM;
          idx_d = '0;
          mgo_d = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        v_d = vfin;
        if (st_q) begin
          state_d = ST_ACC;
        end else begin
          prog_d = sklos_pkg::PG_TRAP;
          idx_d = '0;
          mgo_d = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_ACC: begin
        if (st_q) sum_d = '0;
        else if (tacc[33:31] == 3'b000 || tacc[33:31] == 3'b111) sum_d = 32'(tacc);
        else if (tacc[33]) sum_d = {1'b1, 31'd0};
        else sum_d = {1'b0, {31{1'b1}}};
        pv_d = v_q;
        pz_d = z_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!outv_q || out_ready_i) begin
          out_d = sum_q;
          outv_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ksel_q <= '0;
      pv_q <= '0;
      pz_q <= '0;
      sum_q <= '0;
      outv_q <= 1'b0;
      prog_q <= sklos_pkg::PG_NONE;
      idx_q <= '0;
      mgo_q <= 1'b0;
      sgo_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ksel_q <= ksel_d;
      pv_q <= pv_d;
      pz_q <= pz_d;
      sum_q <= sum_d;
      outv_q <= outv_d;
      prog_q <= prog_d;
      idx_q <= idx_d;
      mgo_q <= mgo_d;
      sgo_q <= sgo_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    za_q <= za_d;
    z_q <= z_d;
    st_q <= st_d;
    dz_q <= dz_d;
    x_q <= x_d;
    r_q <= r_d;
    om_q <= om_d;
    r2_q <= r2_d;
    r3_q <= r3_d;
    r4_q <= r4_d;
    om2_q <= om2_d;
    om3_q <= om3_d;
    t_q <= t_d;
    s_q <= s_d;
    v_q <= v_d;
    mneg_q <= mneg_d;
    out_q <= out_d;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = outv_q;
  assign cumulative_o = out_q;

endmodule
`default_nettype wire

/* verif/sph_kernel_cumulative_los_integrator_unit_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module sph_kernel_cumulative_los_integrator_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [16:0]        impact_q_i,
  input  logic signed [17:0] los_z_i,
  input  logic               row_start_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] cumulative_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  // Predicted copy of the block's register and row state.
  logic [2:0]         shape_sel;
  logic [18:0]        last_weight;
  logic signed [17:0] last_z;
  logic signed [31:0] integral;
  logic signed [31:0] expected_sums[$];

  assign pending_o = expected_sums.size();

  // Decimal constant scaled by 1e10, rounded to Q.24.
  function automatic longint to_q24(longint n);
    return (n * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000;
  endfunction

  // Q.24 product, rounded half away from zero.
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    p = (p + (64'sd1 <<< 23)) >>> 24;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // Kernel shape at radius r (Q0.24), signed Q.24 result.
  function automatic longint shape_at(logic [2:0] sel, longint r);
    longint one, om, r2, r3, r4, om2, om3;
    one = 64'sd1 <<< 24;
    om = one - r;
    r2 = qmul(r, r);
    r3 = qmul(r2, r);
    r4 = qmul(r2, r2);
    om2 = qmul(om, om);
    om3 = qmul(om2, om);
    case (sel)
      sklos_pkg::KSEL_UNI: return to_q24(64'sd2387324146);
      sklos_pkg::KSEL_ANA:
        return qmul(to_q24(64'sd33422538049), qmul(qmul(om2, om2), one + 4 * r));
      sklos_pkg::KSEL_G2: begin
        if (r < (one >>> 1)) return qmul(to_q24(64'sd25464790895), one - 6 * r2 + 6 * r3);
        return qmul(to_q24(64'sd50929581789), om3);
      end
      sklos_pkg::KSEL_CUB: begin
        if (r < (one >>> 1))
          return to_q24(64'sd25464790895) +
                 qmul(to_q24(64'sd152788745368), qmul(r - one, r2));
        return qmul(to_q24(64'sd50929581789), om3);
      end
      sklos_pkg::KSEL_QUI: begin
        if (r < to_q24(64'sd3333333330))
          return 27 * (qmul(to_q24(64'sd64457752000), qmul(r4, one - r)) -
                       qmul(to_q24(64'sd14323945000), r2) + to_q24(64'sd1750704400));
        if (r < to_q24(64'sd6666666670))
          return 27 * (qmul(to_q24(64'sd32228876000), qmul(r4, r - 3 * one)) +
                       qmul(to_q24(64'sd107429587000), r3) -
                       qmul(to_q24(64'sd50133807100), r2) +
                       qmul(to_q24(64'sd5968310366), r) + to_q24(64'sd1352817016));
        return 27 * qmul(to_q24(64'sd6445775200), qmul(qmul(om2, om2), om));
      end
      default: return 0;
    endcase
  endfunction

  // Kernel weight at (q, z) as unsigned Q3.16.
  function automatic logic [18:0] point_weight(logic [2:0] sel, logic [16:0] q,
                                               logic signed [17:0] z);
    longint za, rsq, v;
    za = (z < 0) ? -longint'(z) : longint'(z);
    rsq = za * za + longint'(q) * longint'(q);
    if (rsq >= (64'sd1 <<< 32)) return '0;
    v = shape_at(sel, longint'(int_sqrt(longint'(rsq) << 16)));
    if (v < 0) return '0;
    v = (v + 128) >>> 8;
    if (v > 64'sh7FFFF) v = 64'sh7FFFF;
    return v[18:0];
  endfunction

  // Predict on each accepted request and compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [18:0] w;
    longint dz, mag, acc;
    if (!rst_ni) begin
      shape_sel <= '0;
      last_weight <= '0;
      last_z <= '0;
      integral <= '0;
      fail_count_o <= 0;
      expected_sums.delete();
    end else begin
      if (cfg_we_i) shape_sel <= cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        w = point_weight(shape_sel, impact_q_i, los_z_i);
        if (row_start_i) begin
          acc = 0;
        end else begin
          dz = longint'(los_z_i) - longint'(last_z);
          mag = (longint'(last_weight) + longint'(w)) * (dz < 0 ? -dz : dz);
          mag = (mag + 256) >>> 9;
          acc = longint'(integral) + (dz < 0 ? -mag : mag);
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        end
        integral <= acc[31:0];
        last_weight <= w;
        last_z <= los_z_i;
        expected_sums.push_back(acc[31:0]);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_sums.size() == 0) begin
          if (fail_count_o < 10) $display("[%0t] result %0d with no request pending",
                                          $realtime, cumulative_i);
          fail_count_o <= fail_count_o + 1;
        end else if (expected_sums[0] !== cumulative_i) begin
          if (fail_count_o < 10) $display("[%0t] cumulative: expected %0d, got %0d",
                                          $realtime, expected_sums[0], cumulative_i);
          fail_count_o <= fail_count_o + 1;
          void'(expected_sums.pop_front());
        end else begin
          void'(expected_sums.pop_front());
        end
      end
    end
  end

endmodule
`default_nettype wire

/* verif/sph_kernel_cumulative_los_integrator_unit_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module sph_kernel_cumulative_los_integrator_unit_tb;

  localparam logic [2:0] KSEL_UNUSED_LO = 3'd5;
  localparam logic [2:0] KSEL_UNUSED_HI = 3'd7;

  // Idling modes.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [16:0]        impact_q_i = '0;
  logic signed [17:0] los_z_i = '0;
  logic               row_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] cumulative_o;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 points_sent = 0;

  always #2 clk_i = ~clk_i;

  sph_kernel_cumulative_los_integrator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .impact_q_i  (impact_q_i),
    .los_z_i     (los_z_i),
    .row_start_i (row_start_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cumulative_o(cumulative_o)
  );

  sph_kernel_cumulative_los_integrator_unit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .impact_q_i  (impact_q_i),
    .los_z_i     (los_z_i),
    .row_start_i (row_start_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .cumulative_i(cumulative_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Present one request and hold it until accepted.
  task automatic send_point(logic [16:0] q, logic signed [17:0] z, logic start);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    impact_q_i <= q;
    los_z_i <= z;
    row_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    points_sent++;
  endtask

  // Let every result drain, then write the shape register.
  task automatic select_shape(logic [2:0] sel);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= sel;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Field extremes, support boundary, half and third radii.
  task automatic send_corners();
    send_point(17'd0, 18'sd1000, 1'b0);
    // Most negative z.
    send_point(17'd0, 18'sh20000, 1'b1);
    send_point(17'd131071, 18'sd131071, 1'b0);
    send_point(17'd0, 18'sd0, 1'b0);
    send_point(17'd65536, 18'sd0, 1'b0);
    send_point(17'd65535, 18'sd0, 1'b0);
    send_point(17'd0, 18'sd32768, 1'b0);
    send_point(17'd0, 18'sd21845, 1'b0);
    send_point(17'd0, 18'sd43691, 1'b0);
    send_point(17'd0, -18'sd65536, 1'b0);
    send_point(17'd0, 18'sd65535, 1'b0);
  endtask

  // Mostly well-formed rows with rising z; some requests are pure noise.
  task automatic send_rows(int count);
    int n;
    logic [16:0] q;
    int z;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_point(17'($urandom), 18'($urandom), 1'($urandom));
        n++;
      end else begin
        q = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 70000));
        z = -$urandom_range(10000, 131072);
        for (int i = 0; i < $urandom_range(2, 12); i++) begin
          send_point(q, 18'(z), i == 0);
          z += $urandom_range(1, 24000);
          if (z > 131071) z = 131071;
          n++;
        end
      end
    end
  endtask

  initial begin
    logic [2:0] shapes[8];
    shapes = '{sklos_pkg::KSEL_UNI, sklos_pkg::KSEL_ANA, sklos_pkg::KSEL_G2,
               sklos_pkg::KSEL_CUB, sklos_pkg::KSEL_QUI,
               3'($urandom_range(KSEL_UNUSED_LO, KSEL_UNUSED_HI)), KSEL_UNUSED_HI,
               sklos_pkg::KSEL_QUI};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_corners();
    select_shape(sklos_pkg::KSEL_QUI);
    send_corners();

    for (int ph = 0; ph < 8; ph++) begin
      select_shape(shapes[ph]);
      case (ph % 4)
        IDLE_NONE: begin send_idle_pct = 0; recv_stall_pct = 0; end
        IDLE_SEND: begin send_idle_pct = 51; recv_stall_pct = 0; end
        IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 51; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      send_rows(100);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
    $display("Sent %0d grid points over all kernel shapes, including unused codes,",
             points_sent);
    $display("with sender idling and receiver stalls; %0d mismatches.", fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
